// File: src/etmb_pkg.sv
// Package for the Euler scale-rotate-translate matrix builder.
// Holds the fixed-point constants, the arctangent table and the shared types.
`timescale 1ns / 1ps
package etmb_pkg;

  localparam int CordicSteps = 16;
  localparam logic signed [19:0] AngPi = 20'sd205887;
  localparam logic signed [19:0] AngTwoPi = 20'sd411775;
  localparam logic signed [19:0] AngHalfPi = 20'sd102944;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;

  // Cycles through the sine/cosine pipeline: input register, rotations, rounding
  localparam int TrigLat = CordicSteps + 2;
  // Cycles through the product, scale and saturate stages
  localparam int MatLat = 4;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] m_r0c0;
    logic signed [31:0] m_r0c1;
    logic signed [31:0] m_r0c2;
    logic signed [31:0] m_r1c0;
    logic signed [31:0] m_r1c1;
    logic signed [31:0] m_r1c2;
    logic signed [31:0] m_r2c0;
    logic signed [31:0] m_r2c1;
    logic signed [31:0] m_r2c2;
    logic signed [31:0] m_r3c0;
    logic signed [31:0] m_r3c1;
    logic signed [31:0] m_r3c2;
  } out_item_t;

  // Side data carried alongside the trig pipeline
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } side_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] cx;
    logic signed [15:0] sy;
    logic signed [15:0] cy;
    logic signed [15:0] sz;
    logic signed [15:0] cz;
  } trig_t;

  function automatic logic signed [19:0] atan_lut(input logic [3:0] i);
    logic signed [19:0] r;
    begin
      case (i)
        4'd0: r = 20'sd51472;
        4'd1: r = 20'sd30386;
        4'd2: r = 20'sd16055;
        4'd3: r = 20'sd8150;
        4'd4: r = 20'sd4091;
        4'd5: r = 20'sd2047;
        4'd6: r = 20'sd1024;
        4'd7: r = 20'sd512;
        4'd8: r = 20'sd256;
        4'd9: r = 20'sd128;
        4'd10: r = 20'sd64;
        4'd11: r = 20'sd32;
        4'd12: r = 20'sd16;
        4'd13: r = 20'sd8;
        4'd14: r = 20'sd4;
        4'd15: r = 20'sd2;
        default: r = 20'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/etmb_stream_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing; the payload type is a parameter of the channel.
`timescale 1ns / 1ps
interface etmb_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/etmb_cordic.sv
// Pipelined sine/cosine of one Q4.12 angle: reduce, 16 CORDIC stages, round.
// Depends on etmb_pkg. Advances only when en is high.
`timescale 1ns / 1ps
module etmb_cordic
  import etmb_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  logic signed [15:0] angle,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);

  logic signed [32:0] xs [CordicSteps+1];
  logic signed [32:0] ys [CordicSteps+1];
  logic signed [19:0] zs [CordicSteps+1];
  logic negs [CordicSteps+1];

  logic signed [19:0] z0, z1;
  logic neg0;

  // Reduce the angle into [-pi/2, pi/2]
  always_comb begin
    z0 = 20'(angle) <<< 4;
    neg0 = 1'b0;
    if (z0 > AngPi) z0 = z0 - AngTwoPi;
    if (z0 < -AngPi) z0 = z0 + AngTwoPi;
    z1 = z0;
    if (z0 > AngHalfPi) begin
      z1 = z0 - AngPi;
      neg0 = 1'b1;
    end else if (z0 < -AngHalfPi) begin
      z1 = z0 + AngPi;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CordicGain;
      ys[0] <= '0;
      zs[0] <= z1;
      negs[0] <= neg0;
    end
  end

  // One rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_lut(4'(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_lut(4'(i));
        end
        negs[i+1] <= negs[i];
      end
    end
  end

  logic signed [32:0] xr, yr;
  logic signed [18:0] cq, sq;

  // Round to Q1.15, apply the fold and saturate
  always_comb begin
    xr = (xs[CordicSteps] + 33'sd16384) >>> 15;
    yr = (ys[CordicSteps] + 33'sd16384) >>> 15;
    cq = negs[CordicSteps] ? -xr[18:0] : xr[18:0];
    sq = negs[CordicSteps] ? -yr[18:0] : yr[18:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= (cq > 19'sd32767) ? 16'sh7fff : (cq < -19'sd32768) ? 16'sh8000 : cq[15:0];
      sin_q <= (sq > 19'sd32767) ? 16'sh7fff : (sq < -19'sd32768) ? 16'sh8000 : sq[15:0];
    end
  end

endmodule

// File: src/etmb_matrix.sv
// Rotation products, scaling, rounding and saturation in four register stages.
// Depends on etmb_pkg. Advances only when en is high.
`timescale 1ns / 1ps
module etmb_matrix
  import etmb_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  trig_t trig,
  input  side_t side,
  output out_item_t res
);

  // Stage A: two-factor products in Q.30
  logic signed [31:0] cycx, sycx, sysz, sycz, cysz, cycz, cysx, sysx, sxcz, sxsz;
  logic signed [15:0] a_cx, a_cz, a_sz;
  side_t a_side;
  always_ff @(posedge clk) begin
    if (en) begin
      cycx <= 32'(trig.cy) * 32'(trig.cx);
      sycx <= 32'(trig.sy) * 32'(trig.cx);
      sysz <= 32'(trig.sy) * 32'(trig.sz);
      sycz <= 32'(trig.sy) * 32'(trig.cz);
      cysz <= 32'(trig.cy) * 32'(trig.sz);
      cycz <= 32'(trig.cy) * 32'(trig.cz);
      cysx <= 32'(trig.cy) * 32'(trig.sx);
      sysx <= 32'(trig.sy) * 32'(trig.sx);
      sxcz <= 32'(trig.sx) * 32'(trig.cz);
      sxsz <= 32'(trig.sx) * 32'(trig.sz);
      a_cx <= trig.cx;
      a_cz <= trig.cz;
      a_sz <= trig.sz;
      a_side <= side;
    end
  end

  // Stage B: entries in Q.45, rounded to Q.30
  logic signed [48:0] e45 [9];
  logic signed [33:0] e30 [9];
  always_comb begin
    e45[0] = 49'(cycx) * 49'(a_cz) - (49'(sysz) <<< 15);
    e45[1] = -(49'(cycx) * 49'(a_sz)) - (49'(sycz) <<< 15);
    e45[2] = 49'(cysx) <<< 15;
    e45[3] = 49'(sycx) * 49'(a_cz) + (49'(cysz) <<< 15);
    e45[4] = -(49'(sycx) * 49'(a_sz)) + (49'(cycz) <<< 15);
    e45[5] = 49'(sysx) <<< 15;
    e45[6] = -(49'(sxcz) <<< 15);
    e45[7] = 49'(sxsz) <<< 15;
    e45[8] = 49'(a_cx) <<< 30;
    for (int k = 0; k < 9; k++) begin
      e30[k] = 34'((e45[k] + 49'sd16384) >>> 15);
    end
  end

  logic signed [33:0] b_e [9];
  side_t b_side;
  always_ff @(posedge clk) begin
    if (en) begin
      b_e <= e30;
      b_side <= side_t'(a_side);
    end
  end

  // Stage C: scale times entry in Q.46
  logic signed [65:0] c_p [9];
  side_t c_side;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        c_p[k] <= 66'(k < 3 ? b_side.scale_x : (k < 6 ? b_side.scale_y : b_side.scale_z))
                  * 66'(b_e[k]);
      end
      c_side <= b_side;
    end
  end

  // Stage D: round to Q16.16 and saturate
  logic signed [31:0] sat [9];
  logic signed [65:0] rnd;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd = (c_p[k] + 66'sd536870912) >>> 30;
      if (rnd > 66'sd2147483647) sat[k] = 32'sh7fffffff;
      else if (rnd < -66'sd2147483648) sat[k] = 32'sh80000000;
      else sat[k] = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= '{sat[0], sat[1], sat[2], sat[3], sat[4], sat[5], sat[6], sat[7], sat[8],
               c_side.pos_x, c_side.pos_y, c_side.pos_z};
    end
  end

endmodule

// File: src/euler_trs_matrix_builder.sv
// A request passes through the trig pipeline and then the matrix stages before its result is valid.
// Throughput: one request per cycle; the whole pipeline stalls together
// when the output register is full and not taken, and a stage empty of
// valid data still advances. Reset clears only the valid bits.
// Depends on etmb_pkg, etmb_stream_if, etmb_cordic and etmb_matrix.
`timescale 1ns / 1ps
module euler_trs_matrix_builder
  import etmb_pkg::*;
(
  input logic clk,
  input logic rst,
  etmb_stream_if.sink   in_ch,
  etmb_stream_if.source out_ch
);

  localparam int Depth = TrigLat + MatLat;

  logic [Depth-1:0] vld;
  logic en;
  side_t side_pipe [TrigLat];
  trig_t trig;
  out_item_t res;

  // Advance when the last stage is empty or taken
  assign en = !vld[Depth-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[Depth-1];
  assign out_ch.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_ch.valid};
    end
  end

  // Delay the pass-through fields to line up with the trig results
  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[0] <= '{in_ch.data.pos_x, in_ch.data.pos_y, in_ch.data.pos_z,
                        in_ch.data.scale_x, in_ch.data.scale_y, in_ch.data.scale_z};
      for (int k = 1; k < TrigLat; k++) side_pipe[k] <= side_pipe[k-1];
    end
  end

  etmb_cordic u_cx (.clk, .en, .angle(in_ch.data.angle_x), .sin_q(trig.sx), .cos_q(trig.cx));
  etmb_cordic u_cy (.clk, .en, .angle(in_ch.data.angle_y), .sin_q(trig.sy), .cos_q(trig.cy));
  etmb_cordic u_cz (.clk, .en, .angle(in_ch.data.angle_z), .sin_q(trig.sz), .cos_q(trig.cz));

  etmb_matrix u_mat (.clk, .en, .trig, .side(side_pipe[TrigLat-1]), .res);

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a blocked result");
  a_count: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[0] == $past(in_ch.valid))
    else $error("valid bit lost on entry");
`endif

endmodule
